FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWCR_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SWCR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/swcr_pkg.sv
// Types and constants for the sensor window crop and YUV reorder block
package swcr_pkg;

   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam int unsigned CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_H_START  = 3'd0,
      CSR_H_STOP   = 3'd1,
      CSR_V_START  = 3'd2,
      CSR_V_STOP   = 3'd3,
      CSR_YUV_MODE = 3'd4,
      CSR_ORDER    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ORDER_UYVY = 2'd0,
      ORDER_VYUY = 2'd1,
      ORDER_YUYV = 2'd2,
      ORDER_YVYU = 2'd3
   } yuv_order_type;

   localparam logic [CSR_DATA_BITS-1:0] RESET_H_START = 16'd4;
   localparam logic [CSR_DATA_BITS-1:0] RESET_H_STOP  = 16'd643;
   localparam logic [CSR_DATA_BITS-1:0] RESET_V_START = 16'd4;
   localparam logic [CSR_DATA_BITS-1:0] RESET_V_STOP  = 16'd483;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma;
      logic       line_finish;
      logic       run_last;
      logic       window_error;
   } result_type;

endpackage

FILE: src/sensor_window_crop_yuv_reorder.sv
// Sensor window crop with YUV 4:2:2 pair reorder, top level
//
// Input beats (req_) carry one pixel: luma and chroma bytes plus frame-begin
// and line-finish marks. Column and line counts select pixels inside the
// window [h_start, h_stop] x [v_start, v_stop]; others are dropped.
// Raw mode passes a window pixel as one result beat. YUV mode holds the first
// pixel of a pair and emits two reordered beats on the second; a lone pixel
// at a window line end is emitted unchanged. An invalid window gives one
// error beat per input.
// Results go into a registered four-entry result queue whose head drives
// rsp_. One input beat is taken per cycle while the queue has room for two
// results, so throughput is one pixel per cycle as long as the output drains
// one beat per cycle; a pair gives two result beats.
// Reset (synchronous) empties the queue, clears counts and the held pixel
// and loads the default window. While rsp_stall is high the head beat holds
// and req_stall rises once fewer than two entries are free.
// csr_ writes are registered; the user must issue them only while idle, as the block does not enforce it.
module sensor_window_crop_yuv_reorder #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [swcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_pixel_luma,
   input  logic [7:0]                          req_pixel_chroma,
   input  logic                                req_frame_begin,
   input  logic                                req_line_finish,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_luma,
   output logic [7:0]                          rsp_out_chroma,
   output logic                                rsp_out_line_finish,
   output logic                                rsp_run_last,
   output logic                                rsp_window_error
);

`include "assert_macros.svh"

   localparam int unsigned DEPTH     = 4;
   localparam int unsigned PTR_BITS  = 2;
   localparam int unsigned CNT_BITS  = 3;
   localparam int unsigned DB        = swcr_pkg::CSR_DATA_BITS;

   logic [DB-1:0] h_start_ff, h_stop_ff, v_start_ff, v_stop_ff;
   logic          yuv_mode_ff;
   logic [1:0]    order_ff;

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] line_ff, line_in;
   logic [7:0]            held_luma_ff, held_luma_in;
   logic [7:0]            held_chroma_ff, held_chroma_in;
   logic                  held_valid_ff, held_valid_in;

   swcr_pkg::result_type  queue_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  accept, pop;
   logic [COORD_BITS-1:0] col, line;
   logic [DB-1:0]         col_w, line_w;
   logic                  held_v, err, in_win, wend;
   logic [1:0]            n_res;
   swcr_pkg::result_type  res0, res1;
   swcr_pkg::result_type  head;

   assign accept    = req_valid && !req_stall;
   assign req_stall = count_ff > CNT_BITS'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_start_ff  <= swcr_pkg::RESET_H_START;
         h_stop_ff   <= swcr_pkg::RESET_H_STOP;
         v_start_ff  <= swcr_pkg::RESET_V_START;
         v_stop_ff   <= swcr_pkg::RESET_V_STOP;
         yuv_mode_ff <= 1'b1;
         order_ff    <= swcr_pkg::ORDER_UYVY;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            swcr_pkg::CSR_H_START:  h_start_ff  <= csr_wdata;
            swcr_pkg::CSR_H_STOP:   h_stop_ff   <= csr_wdata;
            swcr_pkg::CSR_V_START:  v_start_ff  <= csr_wdata;
            swcr_pkg::CSR_V_STOP:   v_stop_ff   <= csr_wdata;
            swcr_pkg::CSR_YUV_MODE: yuv_mode_ff <= csr_wdata[0];
            swcr_pkg::CSR_ORDER:    order_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      col    = req_frame_begin ? '0 : column_ff;
      line   = req_frame_begin ? '0 : line_ff;
      held_v = req_frame_begin ? 1'b0 : held_valid_ff;
      col_w  = DB'(col);
      line_w = DB'(line);
      err    = (h_stop_ff <= h_start_ff) || (v_stop_ff < v_start_ff);
      in_win = (line_w >= v_start_ff) && (line_w <= v_stop_ff)
               && (col_w >= h_start_ff) && (col_w <= h_stop_ff);
      wend   = (col_w == h_stop_ff) || req_line_finish;

      n_res          = 2'd0;
      res0           = '{luma: req_pixel_luma, chroma: req_pixel_chroma,
                         line_finish: wend, run_last: 1'b1, window_error: 1'b0};
      res1           = res0;
      held_valid_in  = held_v;
      held_luma_in   = held_luma_ff;
      held_chroma_in = held_chroma_ff;

      if (err) begin
         held_valid_in = 1'b0;
         res0          = '{luma: 8'h00, chroma: 8'h00, line_finish: 1'b0,
                           run_last: 1'b1, window_error: 1'b1};
         n_res         = 2'd1;
      end else if (in_win) begin
         if (!yuv_mode_ff) begin
            held_valid_in = 1'b0;
            n_res         = 2'd1;
         end else if ((col_w[0] ^ h_start_ff[0]) == 1'b0) begin
            if (wend) begin
               held_valid_in = 1'b0;
               n_res         = 2'd1;
            end else begin
               held_luma_in   = req_pixel_luma;
               held_chroma_in = req_pixel_chroma;
               held_valid_in  = 1'b1;
            end
         end else if (!held_v) begin
            n_res = 2'd1;
         end else begin
            held_valid_in    = 1'b0;
            n_res            = 2'd2;
            res0.line_finish = 1'b0;
            res0.run_last    = 1'b0;
            case (swcr_pkg::yuv_order_type'(order_ff))
               swcr_pkg::ORDER_UYVY: begin
                  res0.luma = held_luma_ff;    res0.chroma = held_chroma_ff;
                  res1.luma = req_pixel_luma;  res1.chroma = req_pixel_chroma;
               end
               swcr_pkg::ORDER_VYUY: begin
                  res0.luma = held_luma_ff;    res0.chroma = req_pixel_chroma;
                  res1.luma = req_pixel_luma;  res1.chroma = held_chroma_ff;
               end
               swcr_pkg::ORDER_YUYV: begin
                  res0.luma = held_chroma_ff;   res0.chroma = held_luma_ff;
                  res1.luma = req_pixel_chroma; res1.chroma = req_pixel_luma;
               end
               default: begin
                  res0.luma = req_pixel_chroma; res0.chroma = req_pixel_luma;
                  res1.luma = held_chroma_ff;   res1.chroma = held_luma_ff;
               end
            endcase
         end
      end

      if (req_line_finish) begin
         column_in     = '0;
         line_in       = (line == '1) ? line : line + 1'b1;
         held_valid_in = 1'b0;
      end else begin
         column_in = (col == '1) ? col : col + 1'b1;
         line_in   = line;
      end

      if (!accept) begin
         n_res = 2'd0;
      end
      count_in = count_ff + CNT_BITS'(n_res) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         line_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_luma_ff  <= '0;
         held_chroma_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (accept) begin
            column_ff      <= column_in;
            line_ff        <= line_in;
            held_valid_ff  <= held_valid_in;
            held_luma_ff   <= held_luma_in;
            held_chroma_ff <= held_chroma_in;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(n_res);
         rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign head                = queue_ff[rd_ptr_ff];
   assign rsp_out_luma        = head.luma;
   assign rsp_out_chroma      = head.chroma;
   assign rsp_out_line_finish = head.line_finish;
   assign rsp_run_last        = head.run_last;
   assign rsp_window_error    = head.window_error;

   `SWCR_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH),
      "result queue overfilled")
   `SWCR_ASSERT_SAME(a_accept_room, clock, reset, accept,
      count_ff <= CNT_BITS'(DEPTH - 2), "beat taken without room for a pair")
   `SWCR_ASSERT_NEXT(a_error_emits, clock, reset, accept && err, rsp_valid,
      "error beat not queued")
   `SWCR_ASSERT_SAME(a_error_last, clock, reset, rsp_valid && rsp_window_error,
      rsp_run_last && !rsp_out_line_finish, "error beat not a lone result")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sensor window crop and YUV 4:2:2 reorder block
`timescale 1ns / 100ps

module testbench;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma;
      logic       frame_begin;
      logic       line_finish;
   } pixel_type;

   logic                                csr_write_enable = 1'b0;
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   swcr_pkg::csr_index_type             csr_index = swcr_pkg::CSR_H_START;
   logic [swcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_pixel_luma = '0;
   logic [7:0]                          req_pixel_chroma = '0;
   logic                                req_frame_begin = 1'b0;
   logic                                req_line_finish = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [7:0]                          rsp_out_luma;
   logic [7:0]                          rsp_out_chroma;
   logic                                rsp_out_line_finish;
   logic                                rsp_run_last;
   logic                                rsp_window_error;

   sensor_window_crop_yuv_reorder u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_luma      (req_pixel_luma),
      .req_pixel_chroma    (req_pixel_chroma),
      .req_frame_begin     (req_frame_begin),
      .req_line_finish     (req_line_finish),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_luma        (rsp_out_luma),
      .rsp_out_chroma      (rsp_out_chroma),
      .rsp_out_line_finish (rsp_out_line_finish),
      .rsp_run_last        (rsp_run_last),
      .rsp_window_error    (rsp_window_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // window settings as last written
   logic [15:0]             cfg_h_start = swcr_pkg::RESET_H_START;
   logic [15:0]             cfg_h_stop  = swcr_pkg::RESET_H_STOP;
   logic [15:0]             cfg_v_start = swcr_pkg::RESET_V_START;
   logic [15:0]             cfg_v_stop  = swcr_pkg::RESET_V_STOP;
   logic                    cfg_yuv_enable = 1'b1;
   swcr_pkg::yuv_order_type cfg_order = swcr_pkg::ORDER_UYVY;

   // crop state
   logic [15:0] col_count = '0;
   logic [15:0] line_count = '0;
   logic [7:0]  held_luma = '0;
   logic [7:0]  held_chroma = '0;
   logic        held_valid = 1'b0;

   pixel_type            pending_pixels[$];
   pixel_type            on_wire;
   swcr_pkg::result_type expected_beats[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int accepted = 0;
   int beats_checked = 0;
   int failures = 0;
   int settings = 0;
   int window_pixels = 0;
   int quiet_cycles = 0;

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void queue_result(input logic [7:0] y, input logic [7:0] c,
                                        input logic lf, input logic last,
                                        input logic err);
      expected_beats.push_back(swcr_pkg::result_type'{luma: y, chroma: c,
                                                      line_finish: lf,
                                                      run_last: last,
                                                      window_error: err});
   endfunction

   function automatic void crop_and_reorder(input pixel_type px);
      logic [15:0] col;
      logic [15:0] row;
      logic        bad;
      logic        in_win;
      logic        wend;
      if (px.frame_begin) begin
         col_count  = '0;
         line_count = '0;
         held_valid = 1'b0;
      end
      col    = col_count;
      row    = line_count;
      bad    = (cfg_h_stop <= cfg_h_start) || (cfg_v_stop < cfg_v_start);
      in_win = (row >= cfg_v_start) && (row <= cfg_v_stop) &&
               (col >= cfg_h_start) && (col <= cfg_h_stop);
      wend   = (col == cfg_h_stop) || px.line_finish;
      if (bad || in_win)
         window_pixels++;
      if (bad) begin
         held_valid = 1'b0;
         queue_result(8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
      end else if (in_win) begin
         if (!cfg_yuv_enable) begin
            held_valid = 1'b0;
            queue_result(px.luma, px.chroma, wend, 1'b1, 1'b0);
         end else if (col[0] == cfg_h_start[0]) begin
            if (wend) begin
               held_valid = 1'b0;
               queue_result(px.luma, px.chroma, 1'b1, 1'b1, 1'b0);
            end else begin
               held_luma   = px.luma;
               held_chroma = px.chroma;
               held_valid  = 1'b1;
            end
         end else if (!held_valid) begin
            queue_result(px.luma, px.chroma, wend, 1'b1, 1'b0);
         end else begin
            held_valid = 1'b0;
            case (cfg_order)
               swcr_pkg::ORDER_UYVY: begin
                  queue_result(held_luma, held_chroma, 1'b0, 1'b0, 1'b0);
                  queue_result(px.luma, px.chroma, wend, 1'b1, 1'b0);
               end
               swcr_pkg::ORDER_VYUY: begin
                  queue_result(held_luma, px.chroma, 1'b0, 1'b0, 1'b0);
                  queue_result(px.luma, held_chroma, wend, 1'b1, 1'b0);
               end
               swcr_pkg::ORDER_YUYV: begin
                  queue_result(held_chroma, held_luma, 1'b0, 1'b0, 1'b0);
                  queue_result(px.chroma, px.luma, wend, 1'b1, 1'b0);
               end
               default: begin
                  queue_result(px.chroma, px.luma, 1'b0, 1'b0, 1'b0);
                  queue_result(held_chroma, held_luma, wend, 1'b1, 1'b0);
               end
            endcase
         end
      end
      if (px.line_finish) begin
         col_count  = '0;
         line_count = bump(row);
         held_valid = 1'b0;
      end else begin
         col_count = bump(col);
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            crop_and_reorder(on_wire);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               on_wire = pending_pixels.pop_front();
               req_pixel_luma   <= on_wire.luma;
               req_pixel_chroma <= on_wire.chroma;
               req_frame_begin  <= on_wire.frame_begin;
               req_line_finish  <= on_wire.line_finish;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      swcr_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
               $display("%0t: beat with none expected, expected none actual %0h/%0h",
                        $time, rsp_out_luma, rsp_out_chroma);
               failures++;
            end else begin
               want = expected_beats.pop_front();
               check_field("luma", want.luma, rsp_out_luma);
               check_field("chroma", want.chroma, rsp_out_chroma);
               check_field("line_finish", 8'(want.line_finish), 8'(rsp_out_line_finish));
               check_field("run_last", 8'(want.run_last), 8'(rsp_run_last));
               check_field("window_error", 8'(want.window_error), 8'(rsp_window_error));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Timed out after %0d cycles with no beat", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_pixel(input logic [7:0] y, input logic [7:0] c,
                                     input logic fb, input logic lf);
      pending_pixels.push_back(pixel_type'{luma: y, chroma: c, frame_begin: fb,
                                           line_finish: lf});
   endfunction

   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || expected_beats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input swcr_pkg::csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
   endtask

   task automatic program_window(input logic [15:0] h0, input logic [15:0] h1,
                                 input logic [15:0] v0, input logic [15:0] v1,
                                 input logic en, input swcr_pkg::yuv_order_type ord);
      drain();
      write_csr(swcr_pkg::CSR_H_START, h0);
      write_csr(swcr_pkg::CSR_H_STOP, h1);
      write_csr(swcr_pkg::CSR_V_START, v0);
      write_csr(swcr_pkg::CSR_V_STOP, v1);
      write_csr(swcr_pkg::CSR_YUV_MODE, {15'd0, en});
      write_csr(swcr_pkg::CSR_ORDER, {14'd0, ord});
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_h_start    = h0;
      cfg_h_stop     = h1;
      cfg_v_start    = v0;
      cfg_v_stop     = v1;
      cfg_yuv_enable = en;
      cfg_order      = ord;
      settings++;
      @(negedge clock);
   endtask

   initial begin
      int                      base;
      int                      kind;
      int                      lines;
      int                      width;
      logic [15:0]             h0;
      logic [15:0]             h1;
      logic [15:0]             v0;
      logic [15:0]             v1;
      swcr_pkg::yuv_order_type ord;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 26;
      rx_idle_pct = 52;

      // each pair order, then a lone pixel at the window stop
      for (int i = 0; i < 4; i++) begin
         program_window(16'd0, 16'd2, 16'd0, 16'd0, 1'b1, swcr_pkg::yuv_order_type'(i));
         add_pixel(8'hFF, 8'h00, 1'b1, 1'b0);
         add_pixel(8'h00, 8'hFF, 1'b0, 1'b0);
         add_pixel(8'hA5, 8'h5A, 1'b0, 1'b0);
         add_pixel(8'h5A, 8'hA5, 1'b0, 1'b1);
      end
      // raw passthrough
      program_window(16'd1, 16'd3, 16'd0, 16'd1, 1'b0, swcr_pkg::ORDER_UYVY);
      add_pixel(8'h12, 8'h34, 1'b1, 1'b0);
      add_pixel(8'h56, 8'h78, 1'b0, 1'b0);
      add_pixel(8'h9A, 8'hBC, 1'b0, 1'b1);
      // invalid windows
      program_window(16'd5, 16'd5, 16'd0, 16'd0, 1'b1, swcr_pkg::ORDER_YVYU);
      add_pixel(8'h01, 8'h80, 1'b1, 1'b0);
      add_pixel(8'hFE, 8'h7F, 1'b0, 1'b1);
      program_window(16'd0, 16'd4, 16'd3, 16'd2, 1'b1, swcr_pkg::ORDER_UYVY);
      add_pixel(8'h3C, 8'hC3, 1'b1, 1'b0);
      // mode switched mid-line: second of pair with nothing held
      program_window(16'd0, 16'd7, 16'd0, 16'd0, 1'b0, swcr_pkg::ORDER_UYVY);
      add_pixel(8'h11, 8'h22, 1'b1, 1'b0);
      program_window(16'd0, 16'd7, 16'd0, 16'd0, 1'b1, swcr_pkg::ORDER_VYUY);
      add_pixel(8'h33, 8'h44, 1'b0, 1'b0);
      // held pixel lost to a new frame
      add_pixel(8'h55, 8'h66, 1'b0, 1'b0);
      add_pixel(8'h77, 8'h88, 1'b1, 1'b1);
      drain();

      base = accepted;
      while (accepted - base < 1500) begin
         if (accepted - base < 500) begin
            tx_idle_pct = 26;
            rx_idle_pct = 52;
         end else if (accepted - base < 1000) begin
            tx_idle_pct = 52;
            rx_idle_pct = 26;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         kind = $urandom_range(0, 19);
         h0 = 16'($urandom_range(0, 5));
         h1 = 16'(h0 + $urandom_range(1, 12));
         v0 = 16'($urandom_range(0, 3));
         v1 = 16'(v0 + $urandom_range(0, 4));
         case (kind)
            0: h1 = 16'($urandom_range(0, h0));
            1: begin
               v0 = 16'($urandom_range(1, 4));
               v1 = 16'($urandom_range(0, v0 - 1));
            end
            2: begin
               h0 = 16'h0000;
               h1 = 16'hFFFF;
               v0 = 16'h0000;
               v1 = 16'hFFFF;
            end
            3: begin
               h0 = 16'hFFFF;
               h1 = 16'hFFFF;
               v0 = 16'hFFFF;
               v1 = 16'h0000;
            end
            default: ;
         endcase
         ord = swcr_pkg::yuv_order_type'($urandom_range(0, 3));
         program_window(h0, h1, v0, v1, $urandom_range(0, 3) != 0, ord);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) < 8) begin
               lines = $urandom_range(1, 7);
               for (int l = 0; l < lines; l++) begin
                  width = $urandom_range(1, 16);
                  for (int p = 0; p < width; p++)
                     add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               l == 0 && p == 0, p == width - 1);
               end
            end else begin
               repeat ($urandom_range(4, 20))
                  add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
            end
         end
         drain();
      end

      $display("Sent %0d pixels (%0d in a window or a bad window) over %0d settings",
               accepted, window_pixels, settings);
      $display("Checked %0d result beats: all pair orders, raw mode, bad windows, lone pixels",
               beats_checked);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
